[sv/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Types, constants and table functions for the source tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int POS_BITS = 32;
  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [4:0] {
    C_NUL, C_WS, C_LF, C_CR, C_QUOTE, C_OPAR, C_CPAR, C_STAR, C_PLUS,
    C_COMMA, C_MINUS, C_SLASH, C_DIGIT, C_SEMI, C_LESS, C_EQ, C_SQO,
    C_SQC, C_LETTER, C_OBR, C_CBR, C_INVALID, C_OTHER
  } cls_t;

  typedef enum logic [4:0] {
    S_START = 5'd0, S_WS = 5'd1, S_LF = 5'd2, S_CR = 5'd3, S_OPENLIT = 5'd4,
    S_LIT = 5'd5, S_OPAR = 5'd6, S_CPAR = 5'd7, S_STAR = 5'd8, S_PLUS = 5'd9,
    S_COMMA = 5'd10, S_PLUS2 = 5'd11, S_MINUS = 5'd12, S_SLASH = 5'd13,
    S_NUM = 5'd14, S_LCOM = 5'd15, S_BCOM = 5'd16, S_SEMI = 5'd17,
    S_LESS = 5'd18, S_LESSEQ = 5'd19, S_ASSIGN = 5'd20, S_SQO = 5'd21,
    S_SQC = 5'd22, S_EQ = 5'd23, S_IDENT = 5'd24, S_OBR = 5'd25,
    S_CBR = 5'd26, S_ENDTXT = 5'd27, S_FIN = 5'd30, S_ILL = 5'd31
  } st_t;

  localparam logic [4:0] K_ILLEGAL = 5'd0;
  localparam logic [4:0] K_END     = 5'd1;
  localparam logic [4:0] K_KW0     = 5'd21;

  typedef struct packed {
    logic [4:0]          kind;
    logic [POS_BITS-1:0] start;
    logic [LEN_BITS-1:0] len;
  } tok_t;

  // classification step result for one byte
  typedef struct packed {
    logic n;       // set when two tokens are present (equals v1); counts 0,1,2 are encoded by v0/v1
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } res_t;

  function automatic cls_t classify(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7a) return C_LETTER;
    if (b >= 8'h41 && b <= 8'h5a) return C_LETTER;
    if (b >= 8'h30 && b <= 8'h39) return C_DIGIT;
    case (b)
      8'h00: return C_NUL;
      8'h09, 8'h20: return C_WS;
      8'h0a: return C_LF;
      8'h0d: return C_CR;
      8'h22: return C_QUOTE;
      8'h28: return C_OPAR;
      8'h29: return C_CPAR;
      8'h2a: return C_STAR;
      8'h2b: return C_PLUS;
      8'h2c: return C_COMMA;
      8'h2d: return C_MINUS;
      8'h2f: return C_SLASH;
      8'h3b: return C_SEMI;
      8'h3c: return C_LESS;
      8'h3d: return C_EQ;
      8'h5b: return C_SQO;
      8'h5d: return C_SQC;
      8'h7b: return C_OBR;
      8'h7d: return C_CBR;
      8'h21, 8'h3a, 8'h5c, 8'h5e: return C_INVALID;
      default: return C_OTHER;
    endcase
  endfunction

  function automatic logic in_set(input cls_t c, input logic [22:0] set);
    return set[c];
  endfunction

  function automatic logic [22:0] bit_of(input cls_t c);
    return 23'(1) << c;
  endfunction

  function automatic st_t next_state(input st_t s, input cls_t c);
    case (s)
      S_START: begin
        case (c)
          C_NUL: return S_ENDTXT;
          C_WS: return S_WS;
          C_LF: return S_LF;
          C_CR: return S_CR;
          C_QUOTE: return S_OPENLIT;
          C_OPAR: return S_OPAR;
          C_CPAR: return S_CPAR;
          C_STAR: return S_STAR;
          C_PLUS: return S_PLUS;
          C_COMMA: return S_COMMA;
          C_MINUS: return S_MINUS;
          C_SLASH: return S_SLASH;
          C_DIGIT: return S_NUM;
          C_SEMI: return S_SEMI;
          C_LESS: return S_LESS;
          C_EQ: return S_ASSIGN;
          C_SQO: return S_SQO;
          C_SQC: return S_SQC;
          C_LETTER: return S_IDENT;
          C_OBR: return S_OBR;
          C_CBR: return S_CBR;
          default: return S_ILL;
        endcase
      end
      S_WS: begin
        if (c == C_WS) return S_WS;
        return in_set(c, bit_of(C_CR) | bit_of(C_STAR) | bit_of(C_PLUS) | bit_of(C_SLASH)
                       | bit_of(C_DIGIT) | bit_of(C_LESS) | bit_of(C_EQ) | bit_of(C_LETTER)
                       | bit_of(C_OBR) | bit_of(C_CBR)) ? S_FIN : S_ILL;
      end
      S_LF:
        return in_set(c, bit_of(C_WS) | bit_of(C_CR) | bit_of(C_SLASH) | bit_of(C_LETTER)
                       | bit_of(C_OBR) | bit_of(C_CBR)) ? S_FIN : S_ILL;
      S_CR: return (c == C_LF) ? S_FIN : S_ILL;
      S_OPENLIT: begin
        if (c == C_QUOTE) return S_LIT;
        return in_set(c, bit_of(C_WS) | bit_of(C_OPAR) | bit_of(C_CPAR) | bit_of(C_EQ)
                       | bit_of(C_LETTER) | bit_of(C_INVALID)) ? S_OPENLIT : S_ILL;
      end
      S_LIT: return (c == C_CPAR) ? S_FIN : S_ILL;
      S_OPAR:
        return in_set(c, bit_of(C_QUOTE) | bit_of(C_CPAR) | bit_of(C_DIGIT)
                       | bit_of(C_LETTER)) ? S_FIN : S_ILL;
      S_CPAR:
        return in_set(c, bit_of(C_WS) | bit_of(C_CR) | bit_of(C_CPAR)
                       | bit_of(C_SEMI)) ? S_FIN : S_ILL;
      S_PLUS: begin
        if (c == C_PLUS) return S_PLUS2;
        return (c == C_WS) ? S_FIN : S_ILL;
      end
      S_STAR, S_COMMA, S_LESSEQ, S_EQ: return (c == C_WS) ? S_FIN : S_ILL;
      S_PLUS2: return (c == C_CPAR) ? S_FIN : S_ILL;
      S_MINUS: return (c == C_DIGIT) ? S_FIN : S_ILL;
      S_SLASH: begin
        if (c == C_STAR) return S_BCOM;
        return (c == C_SLASH) ? S_LCOM : S_ILL;
      end
      S_NUM: begin
        if (c == C_DIGIT) return S_NUM;
        return in_set(c, bit_of(C_WS) | bit_of(C_CPAR) | bit_of(C_SEMI)) ? S_FIN : S_ILL;
      end
      S_SEMI: return in_set(c, bit_of(C_WS) | bit_of(C_CR)) ? S_FIN : S_ILL;
      S_LESS: begin
        if (c == C_EQ) return S_LESSEQ;
        return (c == C_WS) ? S_FIN : S_ILL;
      end
      S_ASSIGN: begin
        if (c == C_EQ) return S_EQ;
        return (c == C_WS) ? S_FIN : S_ILL;
      end
      S_SQO: return (c == C_LETTER) ? S_FIN : S_ILL;
      S_SQC: return (c == C_SEMI) ? S_FIN : S_ILL;
      S_IDENT: begin
        if (c == C_LETTER) return S_IDENT;
        return in_set(c, bit_of(C_NUL) | bit_of(C_WS) | bit_of(C_OPAR) | bit_of(C_CPAR)
                       | bit_of(C_PLUS) | bit_of(C_COMMA) | bit_of(C_MINUS) | bit_of(C_SEMI)
                       | bit_of(C_SQO) | bit_of(C_SQC)) ? S_FIN : S_ILL;
      end
      S_OBR: return (c == C_CR) ? S_FIN : S_ILL;
      S_CBR: return in_set(c, bit_of(C_NUL) | bit_of(C_CR)) ? S_FIN : S_ILL;
      default: return S_ILL;
    endcase
  endfunction

  function automatic logic [4:0] kind_of(input st_t s);
    case (s)
      S_LIT: return 5'd2;
      S_OPAR: return 5'd3;
      S_CPAR: return 5'd4;
      S_STAR: return 5'd5;
      S_PLUS: return 5'd6;
      S_COMMA: return 5'd7;
      S_PLUS2: return 5'd8;
      S_MINUS: return 5'd9;
      S_NUM: return 5'd10;
      S_SEMI: return 5'd11;
      S_LESS: return 5'd12;
      S_LESSEQ: return 5'd13;
      S_ASSIGN: return 5'd14;
      S_SQO: return 5'd15;
      S_SQC: return 5'd16;
      S_EQ: return 5'd17;
      S_IDENT: return 5'd18;
      S_OBR: return 5'd19;
      S_CBR: return 5'd20;
      default: return K_ILLEGAL;
    endcase
  endfunction

  // keyword character at index i, zero beyond the keyword's end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
    logic [47:0] w;
    case (k)
      3'd0: w = {8'h00, "yarra"};
      3'd1: w = {8'h00, "tsnoc"};
      3'd2: w = {24'h0, "rof"};
      3'd3: w = {32'h0, "fi"};
      3'd4: w = {24'h0, "tni"};
      3'd5: w = {24'h0, "wen"};
      3'd6: w = "nruter";
      default: w = {16'h0, "diov"};
    endcase
    return (i < 3'd6) ? w[i*8 +: 8] : 8'h00;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0, 3'd1: return 3'd5;
      3'd2, 3'd4, 3'd5: return 3'd3;
      3'd3: return 3'd2;
      3'd6: return 3'd6;
      default: return 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] kw_filter(input logic [7:0] mask,
                                           input logic [LEN_BITS-1:0] idx,
                                           input logic [7:0] b);
    logic [7:0] keep;
    keep = '0;
    for (int k = 0; k < 8; k++) begin
      if (mask[k] && idx < LEN_BITS'(kw_len(3'(k)))
          && kw_char(3'(k), idx[2:0]) == b)
        keep[k] = 1'b1;
    end
    return keep;
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[sv/sst_byte_if.sv]
// ----------------------------------------------------------------------------
// sst_byte_if
// Valid/ready channel carrying one source byte.
// ----------------------------------------------------------------------------
interface sst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

[sv/sst_tok_if.sv]
// ----------------------------------------------------------------------------
// sst_tok_if
// Valid/ready channel carrying one token item.
// ----------------------------------------------------------------------------
interface sst_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;
  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

[sv/sst_scan.sv]
// ----------------------------------------------------------------------------
// sst_scan
// Scanner state and one-byte DFA step; produces up to two tokens per byte.
// ----------------------------------------------------------------------------
module sst_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          b,
  output sst_pkg::res_t       res
);
  import sst_pkg::*;

  st_t                 state;
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] tstart;
  logic [LEN_BITS-1:0] tlen;
  logic [7:0]          kwc;
  logic                star;

  st_t                 state_next;
  logic [POS_BITS-1:0] tstart_next;
  logic [LEN_BITS-1:0] tlen_next;
  logic [7:0]          kwc_next;
  logic                star_next;

  always_comb begin
    cls_t       c;
    st_t        ns;
    st_t        ss;
    logic [4:0] kind;
    logic       emit_p;
    logic       do_start;
    tok_t       pend;
    tok_t       stok;
    logic       stok_v;
    c = classify(b);
    state_next  = state;
    tstart_next = tstart;
    tlen_next   = tlen;
    kwc_next    = kwc;
    star_next   = star;
    res         = '0;
    emit_p      = 1'b0;
    do_start    = 1'b0;
    ns = next_state(state, c);

    // pending token, with keyword match for identifiers
    kind = kind_of(state);
    pend.kind  = kind;
    pend.start = tstart;
    pend.len   = tlen;
    if (state == S_LIT) begin
      pend.start = tstart + 1'b1;
      pend.len   = tlen - LEN_BITS'(2);
    end else if (state == S_IDENT) begin
      for (int k = 7; k >= 0; k--) begin
        if (kwc[k] && tlen == LEN_BITS'(kw_len(3'(k))))
          pend.kind = K_KW0 + 5'(k);
      end
    end

    // start-state step
    ss = next_state(S_START, c);
    stok.kind  = (ss == S_ENDTXT) ? K_END : K_ILLEGAL;
    stok.start = pos;
    stok.len   = LEN_BITS'(1);
    stok_v     = (ss == S_ENDTXT) || (ss == S_ILL);

    if (state == S_LCOM || state == S_BCOM) begin
      tlen_next = len_inc(tlen);
      if (b == 8'h00) begin
        res.v0 = 1'b1;
        res.t0 = '{kind: K_ILLEGAL, start: tstart, len: len_inc(tlen)};
        res.v1 = 1'b1;
        res.t1 = '{kind: K_END, start: pos, len: LEN_BITS'(1)};
        state_next = S_START;
      end else if (state == S_LCOM) begin
        if (b == 8'h0a) state_next = S_START;
      end else if (star && b == 8'h2f) begin
        state_next = S_START;
      end else begin
        star_next = (b == 8'h2a);
      end
      if (state_next == S_START) star_next = 1'b0;
    end else if (state == S_START || state > S_CBR) begin
      do_start = 1'b1;
    end else if (ns == S_FIN) begin
      emit_p   = !(state == S_WS || state == S_LF || state == S_CR);
      do_start = 1'b1;
    end else if (ns == S_ILL) begin
      res.v0 = 1'b1;
      res.t0 = '{kind: K_ILLEGAL, start: tstart, len: len_inc(tlen)};
      state_next = S_START;
    end else begin
      if (ns == S_IDENT) kwc_next = kw_filter(kwc, tlen, b);
      if (ns == S_LCOM || ns == S_BCOM) star_next = 1'b0;
      tlen_next  = len_inc(tlen);
      state_next = ns;
    end

    if (do_start) begin
      if (stok_v) begin
        state_next = S_START;
      end else begin
        state_next  = ss;
        tstart_next = pos;
        tlen_next   = LEN_BITS'(1);
        kwc_next    = (ss == S_IDENT) ? kw_filter(8'hff, '0, b) : 8'hff;
      end
      if (emit_p) begin
        res.v0 = 1'b1;
        res.t0 = pend;
        res.v1 = stok_v;
        res.t1 = stok;
      end else begin
        res.v0 = stok_v;
        res.t0 = stok;
      end
    end
    res.n = res.v1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_START;
      pos    <= '0;
      tstart <= '0;
      tlen   <= '0;
      kwc    <= 8'hff;
      star   <= 1'b0;
    end else if (step) begin
      state  <= state_next;
      pos    <= pos + 1'b1;
      tstart <= tstart_next;
      tlen   <= tlen_next;
      kwc    <= kwc_next;
      star   <= star_next;
    end
  end
endmodule

[sv/sst_out.sv]
// ----------------------------------------------------------------------------
// sst_out
// Result register holding up to two tokens; sends them in order.
// ----------------------------------------------------------------------------
module sst_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sst_pkg::res_t res,
  output logic          can_load,
  sst_tok_if.source     tok
);
  import sst_pkg::*;

  logic v0;
  logic v1;
  tok_t t0;
  tok_t t1;

  // a new byte may enter when at most the final held token leaves this cycle
  assign can_load = !v0 || (!v1 && tok.ready);

  assign tok.valid        = v0;
  assign tok.token_kind   = t0.kind;
  assign tok.token_start  = t0.start;
  assign tok.token_length = t0.len;
  assign tok.last_of_run  = !v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (load) begin
      v0 <= res.v0;
      v1 <= res.v1;
      t0 <= res.t0;
      t1 <= res.t1;
    end else if (v0 && tok.ready) begin
      v0 <= v1;
      v1 <= 1'b0;
      t0 <= t1;
    end
  end
endmodule

[sv/script_source_tokenizer.sv]
// ----------------------------------------------------------------------------
// script_source_tokenizer
// Byte-at-a-time script tokenizer: DFA step plus token result register.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one source byte per item; a zero byte marks end of text.
//   tok carries tokens: kind, start offset, length, and last_of_run set on
//   the last token caused by a byte.
// Timing: a token caused by a byte is registered and valid the cycle after that byte is
//   accepted. Throughput: one byte per cycle while tokens are taken as they
//   appear; a byte that causes two tokens holds the input while both its tokens
//   are held, since the result register sends one token per cycle.
// Reset (rst, synchronous): scanner to its start state, offset counter to
//   zero, result register empty.
// Receiver stall: held tokens stay on tok; src.ready drops until the result
//   register can take the next byte's tokens. Bytes causing no token pass
//   through whenever the register is empty or draining its last token.
// ----------------------------------------------------------------------------
module script_source_tokenizer (
  input logic         clk,
  input logic         rst,
  sst_byte_if.sink    src,
  sst_tok_if.source   tok
);
  import sst_pkg::*;

  res_t res;
  logic can_load;
  logic step;

  assign src.ready = can_load;
  assign step      = src.valid && can_load;

  sst_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .b    (src.source_byte),
    .res  (res)
  );

  sst_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res      (res),
    .can_load (can_load),
    .tok      (tok)
  );
endmodule
